### sv/tccw_pkg.sv
`default_nettype none

package tccw_pkg;

  // Character codes with special meaning on a write
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_ENABLED = 2'd0,
    CFG_FORE    = 2'd1,
    CFG_BACK    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] fore;
    logic [7:0] back;
  } cell_t;

  // Where a sweep starts
  typedef enum logic [1:0] {
    SW_ZERO = 2'd0,
    SW_COPY = 2'd1,
    SW_FILL = 2'd2
  } sweep_src_t;

  // Sweep-addressed write kinds
  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_ZERO  = 2'd1,
    WR_SPACE = 2'd2,
    WR_COPY  = 2'd3
  } wr_sel_t;

  typedef enum logic [1:0] {
    RD_NONE  = 2'd0,
    RD_SWEEP = 2'd1,
    RD_CELL  = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic       latch;
    logic       emit;
    logic       sweep_load;
    sweep_src_t sweep_src;
    logic       sweep_inc;
    wr_sel_t    wr_sel;
    rd_sel_t    rd_sel;
    logic       home;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic enabled;
    logic need_scroll;
    logic emit_last;
    logic tab_done;
    logic sweep_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### sv/tccw_datapath.sv
`default_nettype none

module tccw_datapath #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tccw_pkg::cmd_t   cmd,
  output tccw_pkg::status_t     status,
  input  wire logic [1:0]       in_operation,
  input  wire logic [7:0]       in_char_code,
  input  wire logic [4:0]       in_read_row,
  input  wire logic [6:0]       in_read_column,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output logic [7:0]            out_cell_char,
  output logic [7:0]            out_cell_fore,
  output logic [7:0]            out_cell_back,
  output logic [4:0]            out_cursor_row,
  output logic [6:0]            out_cursor_column,
  output logic                  out_scrolled,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [7:0]       cfg_wdata
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int TAB_W  = $clog2(TAB_WIDTH + 1);

  localparam logic [ROW_W-1:0]  ROWS_N    = ROW_W'(ROWS);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COLS_N    = COL_W'(COLUMNS);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ADDR_COLS = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] ADDR_FILL = ADDR_W'((ROWS - 1) * COLUMNS);

  // Configuration
  logic       enabled_r;
  logic [7:0] fore_r;
  logic [7:0] back_r;

  // Latched item
  tccw_pkg::op_t op_r;
  logic [7:0]    char_r;
  logic [4:0]    rrow_r;
  logic [6:0]    rcol_r;
  logic [TAB_W-1:0] tab_cnt_r;

  // Cursor and sweep
  logic [ROW_W-1:0]  cur_row_r;
  logic [COL_W-1:0]  cur_col_r;
  logic              scrolled_r;
  logic [ADDR_W-1:0] sweep_r;

  // Cell memory
  tccw_pkg::cell_t   mem [CELLS];
  tccw_pkg::cell_t   rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  tccw_pkg::cell_t   mem_wd;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_ra;

  logic              out_valid_r;

  // Emit step
  logic [7:0]        emit_ch;
  logic [7:0]        wr_ch;
  logic              emit_wr;
  logic [ROW_W-1:0]  r1;
  logic [COL_W-1:0]  c1;
  logic [ROW_W-1:0]  wr_row;
  logic [COL_W-1:0]  wr_col;
  logic              need_scroll;
  logic [ROW_W-1:0]  r_fin;
  logic [ADDR_W-1:0] emit_addr;

  logic              rd_in_range;
  logic [ADDR_W-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      fore_r    <= 8'd15;
      back_r    <= 8'd0;
    end else if (cfg_we) begin
      case (tccw_pkg::cfg_idx_t'(cfg_index))
        tccw_pkg::CFG_ENABLED: enabled_r <= cfg_wdata[0];
        tccw_pkg::CFG_FORE:    fore_r    <= cfg_wdata;
        tccw_pkg::CFG_BACK:    back_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= tccw_pkg::op_t'(in_operation);
      char_r <= in_char_code;
      rrow_r <= in_read_row;
      rcol_r <= in_read_column;
    end
  end

  always_comb begin
    emit_ch = (char_r == tccw_pkg::CH_TAB) ? tccw_pkg::CH_SPACE : char_r;
    r1      = cur_row_r;
    c1      = cur_col_r;
    wr_row  = cur_row_r;
    wr_col  = cur_col_r;
    wr_ch   = emit_ch;
    emit_wr = 1'b1;
    priority if (emit_ch == tccw_pkg::CH_NEWLINE) begin
      c1      = '0;
      r1      = cur_row_r + ROW_W'(1);
      emit_wr = 1'b0;
    end else if (emit_ch == tccw_pkg::CH_BACKSPACE) begin
      priority if (cur_col_r != '0) begin
        c1 = cur_col_r - COL_W'(1);
      end else if (cur_row_r != '0) begin
        r1 = cur_row_r - ROW_W'(1);
        c1 = COL_LAST;
      end else begin
        c1 = cur_col_r;
      end
      wr_row = r1;
      wr_col = c1;
      wr_ch  = tccw_pkg::CH_SPACE;
    end else begin
      c1 = cur_col_r + COL_W'(1);
    end
    // wrap at the end of a line
    if (c1 == COLS_N) begin
      c1 = '0;
      r1 = r1 + ROW_W'(1);
    end
    need_scroll = (r1 == ROWS_N);
    r_fin       = need_scroll ? ROW_LAST : r1;
    emit_addr   = ADDR_W'(wr_row) * ADDR_COLS + ADDR_W'(wr_col);
  end

  assign rd_in_range = (32'(rrow_r) < ROWS) && (32'(rcol_r) < COLUMNS);
  assign rd_addr     = ADDR_W'(32'(rrow_r) * COLUMNS + 32'(rcol_r));

  always_comb begin
    mem_we = 1'b0;
    mem_wa = sweep_r;
    mem_wd = '0;
    priority if (cmd.emit) begin
      mem_we = emit_wr;
      mem_wa = emit_addr;
      mem_wd = '{ch: wr_ch, fore: fore_r, back: back_r};
    end else begin
      unique case (cmd.wr_sel)
        tccw_pkg::WR_NONE: ;
        tccw_pkg::WR_ZERO: mem_we = 1'b1;
        tccw_pkg::WR_SPACE: begin
          mem_we = 1'b1;
          mem_wd = '{ch: tccw_pkg::CH_SPACE, fore: fore_r, back: back_r};
        end
        tccw_pkg::WR_COPY: begin
          mem_we = 1'b1;
          mem_wa = sweep_r - ADDR_COLS;
          mem_wd = rdata_r;
        end
      endcase
    end
  end

  always_comb begin
    mem_re = 1'b0;
    mem_ra = sweep_r;
    unique case (cmd.rd_sel)
      tccw_pkg::RD_NONE:  ;
      tccw_pkg::RD_SWEEP: mem_re = 1'b1;
      tccw_pkg::RD_CELL: begin
        mem_re = rd_in_range;
        mem_ra = rd_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r  <= '0;
      cur_col_r  <= '0;
      scrolled_r <= 1'b0;
      sweep_r    <= '0;
      tab_cnt_r  <= '0;
    end else begin
      if (cmd.latch) begin
        scrolled_r <= 1'b0;
        tab_cnt_r  <= (in_char_code == tccw_pkg::CH_TAB) ? TAB_W'(TAB_WIDTH) : TAB_W'(1);
      end
      if (cmd.emit) begin
        cur_row_r <= r_fin;
        cur_col_r <= c1;
        if (need_scroll) begin
          scrolled_r <= 1'b1;
        end
        if (tab_cnt_r != '0) begin
          tab_cnt_r <= tab_cnt_r - TAB_W'(1);
        end
      end
      if (cmd.home) begin
        cur_row_r <= '0;
        cur_col_r <= '0;
      end
      if (cmd.sweep_load) begin
        unique case (cmd.sweep_src)
          tccw_pkg::SW_ZERO: sweep_r <= '0;
          tccw_pkg::SW_COPY: sweep_r <= ADDR_COLS;
          tccw_pkg::SW_FILL: sweep_r <= ADDR_FILL;
          default:           sweep_r <= '0;
        endcase
      end else if (cmd.sweep_inc) begin
        sweep_r <= sweep_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (op_r == tccw_pkg::OP_READ && rd_in_range) begin
        out_cell_char <= rdata_r.ch;
        out_cell_fore <= rdata_r.fore;
        out_cell_back <= rdata_r.back;
      end else begin
        out_cell_char <= '0;
        out_cell_fore <= '0;
        out_cell_back <= '0;
      end
      out_cursor_row    <= 5'(cur_row_r);
      out_cursor_column <= 7'(cur_col_r);
      out_scrolled      <= scrolled_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    status.op          = op_r;
    status.enabled     = enabled_r;
    status.need_scroll = need_scroll;
    status.emit_last   = (tab_cnt_r == TAB_W'(1));
    status.tab_done    = (tab_cnt_r == '0);
    status.sweep_last  = (sweep_r == ADDR_LAST);
    status.out_free    = !out_valid_r || !out_stall;
  end

  a_latch_clears_scrolled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> !scrolled_r)
    else $error("scrolled flag not cleared for a new item");

  a_scroll_parks_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && need_scroll |=> scrolled_r && (cur_row_r == ROW_LAST))
    else $error("scroll did not leave cursor on the bottom row");

  a_cursor_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_row_r < ROWS_N) && (cur_col_r < COLS_N))
    else $error("cursor outside the screen");

endmodule

`default_nettype wire

### sv/tccw_ctrl.sv
`default_nettype none

module tccw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tccw_pkg::status_t status,
  output tccw_pkg::cmd_t         cmd
);

  typedef enum logic [8:0] {
    ST_INIT   = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_DECODE = 9'b000000100,
    ST_EMIT   = 9'b000001000,
    ST_SCR_RD = 9'b000010000,
    ST_SCR_WR = 9'b000100000,
    ST_FILL   = 9'b001000000,
    ST_CLEAR  = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.sweep_src  = tccw_pkg::SW_ZERO;
    cmd.wr_sel     = tccw_pkg::WR_NONE;
    cmd.rd_sel     = tccw_pkg::RD_NONE;
    in_stall       = 1'b1;
    unique case (state_r)
      ST_INIT: begin
        cmd.wr_sel = tccw_pkg::WR_ZERO;
        if (status.sweep_last) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (status.op)
          tccw_pkg::OP_WRITE: state_nxt = status.enabled ? ST_EMIT : ST_FINISH;
          tccw_pkg::OP_CLEAR: begin
            if (status.enabled) begin
              cmd.sweep_load = 1'b1;
              cmd.sweep_src  = tccw_pkg::SW_ZERO;
              state_nxt      = ST_CLEAR;
            end else begin
              state_nxt = ST_FINISH;
            end
          end
          tccw_pkg::OP_READ: begin
            cmd.rd_sel = tccw_pkg::RD_CELL;
            state_nxt  = ST_FINISH;
          end
          tccw_pkg::OP_NONE: state_nxt = ST_FINISH;
        endcase
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        priority if (status.need_scroll) begin
          cmd.sweep_load = 1'b1;
          cmd.sweep_src  = tccw_pkg::SW_COPY;
          state_nxt      = ST_SCR_RD;
        end else if (status.emit_last) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SCR_RD: begin
        cmd.rd_sel = tccw_pkg::RD_SWEEP;
        state_nxt  = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        cmd.wr_sel = tccw_pkg::WR_COPY;
        if (status.sweep_last) begin
          cmd.sweep_load = 1'b1;
          cmd.sweep_src  = tccw_pkg::SW_FILL;
          state_nxt      = ST_FILL;
        end else begin
          cmd.sweep_inc = 1'b1;
          state_nxt     = ST_SCR_RD;
        end
      end
      ST_FILL: begin
        cmd.wr_sel = tccw_pkg::WR_SPACE;
        if (status.sweep_last) begin
          state_nxt = status.tab_done ? ST_FINISH : ST_EMIT;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      ST_CLEAR: begin
        cmd.wr_sel = tccw_pkg::WR_SPACE;
        if (status.sweep_last) begin
          cmd.home  = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_DECODE)
    else $error("accepted item did not reach decode");

  a_copy_then_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCR_WR) && status.sweep_last |=> state_r == ST_FILL)
    else $error("scroll copy did not hand over to bottom-row fill");

endmodule

`default_nettype wire

### sv/text_console_cell_writer.sv
`default_nettype none

// Character-cell console store of ROWS x COLUMNS cells (character, foreground,
// background), with a cursor. Each accepted input transfer yields exactly one
// result transfer carrying the cursor after the operation, a scrolled flag and,
// for a read, the addressed cell. After reset a clearing pass writes zero to
// every cell, one a cycle, while in_stall stays high; configuration writes
// are taken throughout. One item is worked at a time: it is latched and
// decoded, a write then takes its emit steps (TAB_WIDTH of them for a tab),
// and the result goes on once the output register is free. A clear sweeps
// the cell memory one cell a cycle. Each scroll copies the screen up through
// the read and write ports of the cell memory, a read and a write per cell,
// then fills the bottom row. The result sits in an output register, so the
// next item is accepted while it waits.
module text_console_cell_writer #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_operation,
  input  wire logic [7:0] in_char_code,
  input  wire logic [4:0] in_read_row,
  input  wire logic [6:0] in_read_column,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_cell_char,
  output logic [7:0]      out_cell_fore,
  output logic [7:0]      out_cell_back,
  output logic [4:0]      out_cursor_row,
  output logic [6:0]      out_cursor_column,
  output logic            out_scrolled,
  // configuration write port
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  // Commands from the sequencer, status back from the datapath
  tccw_pkg::cmd_t    cmd;
  tccw_pkg::status_t status;

  // Sequencer: clearing pass, decode, emit steps, scroll and clear sweeps,
  // and the hand-over of the result to the output register
  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: cell memory, cursor, sweep address, item latch, configuration
  // registers and the result register
  tccw_datapath #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_operation      (in_operation),
    .in_char_code      (in_char_code),
    .in_read_row       (in_read_row),
    .in_read_column    (in_read_column),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_cell_char     (out_cell_char),
    .out_cell_fore     (out_cell_fore),
    .out_cell_back     (out_cell_back),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_column (out_cursor_column),
    .out_scrolled      (out_scrolled),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

endmodule

`default_nettype wire

### dv/console_shadow_check.sv
module console_shadow_check #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [1:0] in_operation,
  input  wire logic [7:0] in_char_code,
  input  wire logic [4:0] in_read_row,
  input  wire logic [6:0] in_read_column,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [7:0] out_cell_char,
  input  wire logic [7:0] out_cell_fore,
  input  wire logic [7:0] out_cell_back,
  input  wire logic [4:0] out_cursor_row,
  input  wire logic [6:0] out_cursor_column,
  input  wire logic       out_scrolled,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  output int              mismatches,
  output int              reports_waiting,
  output int              reports_checked,
  output int              scroll_reports
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = ROWS * COLUMNS;

  typedef struct packed {
    tccw_pkg::cell_t rd_cell;
    logic [4:0]      row;
    logic [6:0]      col;
    logic            scrolled;
  } report_t;

  tccw_pkg::cell_t shadow [CELLS];
  int unsigned     cur_r;
  int unsigned     cur_c;
  logic            en_q;
  logic [7:0]      fore_q;
  logic [7:0]      back_q;
  report_t         reports_due [$];

  function automatic void paint(int unsigned idx, logic [7:0] ch);
    if (idx < CELLS) begin
      shadow[idx] = {ch, fore_q, back_q};
    end
  endfunction

  function automatic void roll_up();
    for (int i = 0; i < CELLS - COLUMNS; i++) begin
      shadow[i] = shadow[i + COLUMNS];
    end
    for (int c = 0; c < COLUMNS; c++) begin
      paint((ROWS - 1) * COLUMNS + c, tccw_pkg::CH_SPACE);
    end
  endfunction

  // One character at the cursor; tells whether the screen rolled up
  function automatic logic type_char(logic [7:0] ch);
    logic rolled;
    rolled = 1'b0;
    if (ch == tccw_pkg::CH_NEWLINE) begin
      cur_c = 0;
      cur_r++;
    end else if (ch == tccw_pkg::CH_BACKSPACE) begin
      if (cur_c > 0) begin
        cur_c--;
      end else if (cur_r > 0) begin
        cur_r--;
        cur_c = COLUMNS - 1;
      end
      paint(cur_r * COLUMNS + cur_c, tccw_pkg::CH_SPACE);
    end else begin
      paint(cur_r * COLUMNS + cur_c, ch);
      cur_c++;
    end
    if (cur_c >= COLUMNS) begin
      cur_c = 0;
      cur_r++;
    end
    if (cur_r >= ROWS) begin
      roll_up();
      cur_r  = ROWS - 1;
      rolled = 1'b1;
    end
    return rolled;
  endfunction

  function automatic report_t console_apply(logic [1:0] op_bits, logic [7:0] ch,
                                            logic [4:0] rr, logic [6:0] rc);
    report_t rep;
    rep = '0;
    case (tccw_pkg::op_t'(op_bits))
      tccw_pkg::OP_WRITE: begin
        if (en_q) begin
          if (ch == tccw_pkg::CH_TAB) begin
            for (int i = 0; i < TAB_WIDTH; i++) begin
              if (type_char(tccw_pkg::CH_SPACE)) rep.scrolled = 1'b1;
            end
          end else begin
            rep.scrolled = type_char(ch);
          end
        end
      end
      tccw_pkg::OP_CLEAR: begin
        if (en_q) begin
          for (int i = 0; i < CELLS; i++) begin
            paint(i, tccw_pkg::CH_SPACE);
          end
          cur_r = 0;
          cur_c = 0;
        end
      end
      tccw_pkg::OP_READ: begin
        if (rr < ROWS && rc < COLUMNS) begin
          rep.rd_cell = shadow[rr * COLUMNS + rc];
        end
      end
      default: begin
      end
    endcase
    rep.row = cur_r[4:0];
    rep.col = cur_c[6:0];
    return rep;
  endfunction

  always @(posedge clk) begin
    report_t want;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) begin
        shadow[i] = '0;
      end
      cur_r  = 0;
      cur_c  = 0;
      en_q   = 1'b0;
      fore_q = 8'd15;
      back_q = 8'd0;
      reports_due.delete();
    end else begin
      if (cfg_we) begin
        case (tccw_pkg::cfg_idx_t'(cfg_index))
          tccw_pkg::CFG_ENABLED: en_q   = cfg_wdata[0];
          tccw_pkg::CFG_FORE:    fore_q = cfg_wdata;
          tccw_pkg::CFG_BACK:    back_q = cfg_wdata;
          default: begin
          end
        endcase
      end
      // take the result side first, so an empty queue is never hidden
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] result transfer with nothing awaited", $realtime);
          end
        end else begin
          want = reports_due.pop_front();
          reports_checked++;
          if (want.scrolled) scroll_reports++;
          if (out_cell_char !== want.rd_cell.ch || out_cell_fore !== want.rd_cell.fore ||
              out_cell_back !== want.rd_cell.back || out_cursor_row !== want.row ||
              out_cursor_column !== want.col || out_scrolled !== want.scrolled) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result %0d (expected/actual): char %0d/%0d fore %0d/%0d",
                       $realtime, reports_checked, want.rd_cell.ch, out_cell_char,
                       want.rd_cell.fore, out_cell_fore);
              $display("    back %0d/%0d row %0d/%0d column %0d/%0d scrolled %0d/%0d",
                       want.rd_cell.back, out_cell_back, want.row, out_cursor_row,
                       want.col, out_cursor_column, want.scrolled, out_scrolled);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        reports_due.push_back(console_apply(in_operation, in_char_code,
                                            in_read_row, in_read_column));
      end
    end
    reports_waiting = reports_due.size();
  end

endmodule

### dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 4;
  // Worst item: a scroll plus gaps on both sides, for every item, after the
  // clearing pass; then taken a few times over.
  localparam int unsigned LIMIT = 30_000_000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_operation = '0;
  logic [7:0] in_char_code = '0;
  logic [4:0] in_read_row = '0;
  logic [6:0] in_read_column = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_cell_char;
  logic [7:0] out_cell_fore;
  logic [7:0] out_cell_back;
  logic [4:0] out_cursor_row;
  logic [6:0] out_cursor_column;
  logic       out_scrolled;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;

  int mismatches;
  int reports_waiting;
  int reports_checked;
  int scroll_reports;

  int unsigned cycles = 0;
  int          idle_pct = 29;   // chance in a hundred that the sender holds off
  int          stall_pct = 29;  // chance in a hundred that the receiver stalls
  int          n_writes, n_clears, n_reads, n_other, n_settings, items_sent;

  // Last cursor the block reported; steers reads towards freshly typed cells
  logic [4:0] last_row = '0;
  logic [6:0] last_col = '0;

  always #5ns clk = ~clk;

  text_console_cell_writer #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_char_code     (in_char_code),
    .in_read_row      (in_read_row),
    .in_read_column   (in_read_column),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cell_char    (out_cell_char),
    .out_cell_fore    (out_cell_fore),
    .out_cell_back    (out_cell_back),
    .out_cursor_row   (out_cursor_row),
    .out_cursor_column(out_cursor_column),
    .out_scrolled     (out_scrolled),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  console_shadow_check #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_char_code     (in_char_code),
    .in_read_row      (in_read_row),
    .in_read_column   (in_read_column),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cell_char    (out_cell_char),
    .out_cell_fore    (out_cell_fore),
    .out_cell_back    (out_cell_back),
    .out_cursor_row   (out_cursor_row),
    .out_cursor_column(out_cursor_column),
    .out_scrolled     (out_scrolled),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatches       (mismatches),
    .reports_waiting  (reports_waiting),
    .reports_checked  (reports_checked),
    .scroll_reports   (scroll_reports)
  );

  // Receiver back-pressure: redraw the stall every cycle, independent of valid
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Remember the cursor from each result transfer
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      last_row <= out_cursor_row;
      last_col <= out_cursor_column;
    end
  end

  // Watchdog: give up if the run hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycles,
               reports_waiting);
      $display("text_console_cell_writer test failed");
      $finish;
    end
  end

  // One input transfer. Hold off at random first (valid low), then present the
  // item and hold it until the block stops stalling. Valid stays high on return,
  // so back-to-back transfers never lower and raise it in one step.
  task automatic pass_item(tccw_pkg::op_t op, logic [7:0] ch, logic [4:0] rr,
                           logic [6:0] rc);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_char_code   <= ch;
    in_read_row    <= rr;
    in_read_column <= rc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    case (op)
      tccw_pkg::OP_WRITE: n_writes++;
      tccw_pkg::OP_CLEAR: n_clears++;
      tccw_pkg::OP_READ:  n_reads++;
      default:            n_other++;
    endcase
  endtask

  // Drop valid and wait until every awaited result has come back. The count is
  // looked at on the falling edge, clear of the rising-edge updates.
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(negedge clk); while (reports_waiting != 0);
    @(posedge clk);
  endtask

  // Write all three registers on consecutive edges, only while the block idles.
  // Spare bits of the enable write carry noise, which the block must ignore.
  task automatic set_console(logic en, logic [7:0] fg, logic [7:0] bg);
    cfg_we    <= 1'b1;
    cfg_index <= tccw_pkg::CFG_ENABLED;
    cfg_wdata <= {7'($urandom), en};
    @(posedge clk);
    cfg_index <= tccw_pkg::CFG_FORE;
    cfg_wdata <= fg;
    @(posedge clk);
    cfg_index <= tccw_pkg::CFG_BACK;
    cfg_wdata <= bg;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(99);
    if (r < 5) return tccw_pkg::CH_BACKSPACE;
    if (r < 10) return tccw_pkg::CH_TAB;
    if (r < 13) return tccw_pkg::CH_NEWLINE;
    return 8'($urandom_range(255));
  endfunction

  // A typed line: mostly short, now and then long enough to wrap, usually
  // closed by a newline. Read fields carry noise, which writes ignore.
  task automatic type_line();
    int len;
    len = ($urandom_range(99) < 15) ? $urandom_range(90, 60) : $urandom_range(12, 1);
    repeat (len) begin
      pass_item(tccw_pkg::OP_WRITE, rand_char(), 5'($urandom), 7'($urandom));
    end
    if ($urandom_range(99) < 60) begin
      pass_item(tccw_pkg::OP_WRITE, tccw_pkg::CH_NEWLINE, 5'($urandom), 7'($urandom));
    end
  endtask

  // A burst of reads: near the cursor, anywhere on screen, or anywhere the
  // field widths reach (out-of-range rows and columns included)
  task automatic read_back();
    int         r;
    logic [4:0] rr;
    logic [6:0] rc;
    repeat ($urandom_range(6, 1)) begin
      r = $urandom_range(99);
      if (r < 45) begin
        rr = (last_row > 0 && $urandom_range(1)) ? last_row - 5'd1 : last_row;
        rc = ($urandom_range(1)) ? 7'($urandom_range(COLUMNS - 1)) : last_col;
      end else if (r < 85) begin
        rr = 5'($urandom_range(ROWS - 1));
        rc = 7'($urandom_range(COLUMNS - 1));
      end else begin
        rr = 5'($urandom);
        rc = 7'($urandom);
      end
      pass_item(tccw_pkg::OP_READ, 8'($urandom), rr, rc);
    end
  endtask

  // One random sequence: lines of text and read bursts dominate, with clears,
  // the unused code and lone arbitrary bytes as noise
  task automatic run_sequence(int clear_pct);
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      type_line();
    end else if (r < 75) begin
      read_back();
    end else if (r < 75 + clear_pct) begin
      pass_item(tccw_pkg::OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
    end else if (r < 80 + clear_pct) begin
      pass_item(tccw_pkg::OP_NONE, 8'($urandom), 5'($urandom), 7'($urandom));
    end else begin
      pass_item(tccw_pkg::OP_WRITE, 8'($urandom), 5'($urandom), 7'($urandom));
    end
  endtask

  initial begin
    int   fg, bg, clear_pct, quota, start;
    logic en;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: still at reset settings, so the console is switched off.
    // Reads work, writes and clears leave nothing behind. The first transfer
    // also waits out the clearing pass after reset.
    pass_item(tccw_pkg::OP_READ,  8'd0,   5'd0, 7'd0);
    pass_item(tccw_pkg::OP_WRITE, 8'd65,  5'd31, 7'd127);
    pass_item(tccw_pkg::OP_CLEAR, 8'd255, 5'd0, 7'd0);
    pass_item(tccw_pkg::OP_READ,  8'd0,   5'd0, 7'd0);
    pass_item(tccw_pkg::OP_NONE,  8'd0,   5'd0, 7'd0);
    quiesce();
    set_console(1'b1, 8'd255, 8'd0);

    // Backspace at the origin blanks cell 0 and stays put
    pass_item(tccw_pkg::OP_WRITE, tccw_pkg::CH_BACKSPACE, 5'd0, 7'd0);
    pass_item(tccw_pkg::OP_READ,  8'd0, 5'd0, 7'd0);
    // Byte extremes, a tab, a newline, then backspace across the row boundary
    pass_item(tccw_pkg::OP_WRITE, 8'd255, 5'd0, 7'd0);
    pass_item(tccw_pkg::OP_WRITE, 8'd0,   5'd0, 7'd0);
    pass_item(tccw_pkg::OP_WRITE, tccw_pkg::CH_TAB, 5'd0, 7'd0);
    pass_item(tccw_pkg::OP_WRITE, tccw_pkg::CH_NEWLINE, 5'd0, 7'd0);
    pass_item(tccw_pkg::OP_WRITE, tccw_pkg::CH_BACKSPACE, 5'd0, 7'd0);
    pass_item(tccw_pkg::OP_READ,  8'd0, 5'd0, 7'd79);
    pass_item(tccw_pkg::OP_READ,  8'd0, 5'd0, 7'd1);
    // A character in the last column wraps the cursor to the next row
    pass_item(tccw_pkg::OP_WRITE, 8'd122, 5'd0, 7'd0);
    // Reads outside the screen return an empty cell
    pass_item(tccw_pkg::OP_READ,  8'd0, 5'd31, 7'd127);
    pass_item(tccw_pkg::OP_READ,  8'd0, 5'd24, 7'd80);
    pass_item(tccw_pkg::OP_READ,  8'd0, 5'd25, 7'd0);
    pass_item(tccw_pkg::OP_NONE,  8'd255, 5'd31, 7'd127);
    // Clear, then the far corner must hold a space
    pass_item(tccw_pkg::OP_CLEAR, 8'd0, 5'd0, 7'd0);
    pass_item(tccw_pkg::OP_READ,  8'd0, 5'd24, 7'd79);
    pass_item(tccw_pkg::OP_READ,  8'd0, 5'd0, 7'd0);

    // Random phases, one register setting each. Only the clearing phases ever
    // home the cursor, so the others push it down to the bottom row and scroll.
    // The disabled phase is short, with 60 items instead of 175.
    for (int p = 0; p < 9; p++) begin
      en        = 1'b1;
      fg        = $urandom_range(255);
      bg        = $urandom_range(255);
      clear_pct = (p == 3 || p == 7) ? 4 : 0;
      quota     = 175;
      idle_pct  = 29;
      stall_pct = 29;
      case (p)
        0: begin
          fg = 0;
          bg = 255;
        end
        1: begin
          fg        = 255;
          bg        = 255;
          idle_pct  = 0;   // a long stretch at full rate on both sides
          stall_pct = 0;
        end
        4: begin
          en    = 1'b0;
          quota = 60;
        end
        8: begin
          fg = 0;
          bg = 0;
        end
        default: begin
        end
      endcase
      quiesce();
      set_console(en, 8'(fg), 8'(bg));
      start = items_sent;
      while (items_sent - start < quota) run_sequence(clear_pct);
    end

    // Let every awaited result arrive, then keep the clock running so that
    // anything spurious can still show up
    quiesce();
    repeat (16) @(posedge clk);

    $display("Covered %0d writes, %0d clears, %0d reads, %0d unused codes, %0d settings",
             n_writes, n_clears, n_reads, n_other, n_settings);
    $display("Compared %0d results, %0d of them after a scroll; %0d mismatches",
             reports_checked, scroll_reports, mismatches);
    if (mismatches == 0 && reports_waiting == 0) begin
      $display("text_console_cell_writer test passed");
    end else begin
      $display("text_console_cell_writer test failed");
    end
    $finish;
  end

endmodule
